// ----- hdl/trajectory_shape_classifier_top_macros.svh -----
// assertion macros for the trajectory shape classifier
// used by trajectory_shape_classifier_top, no other dependencies
`ifndef TRAJECTORY_SHAPE_CLASSIFIER_TOP_MACROS_SVH
`define TRAJECTORY_SHAPE_CLASSIFIER_TOP_MACROS_SVH

// same-cycle implication
`define TSC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("trajectory shape classifier check failed");

// next-cycle implication
`define TSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("trajectory shape classifier check failed");

`endif

// ----- hdl/tsc_pkg.sv -----
// shared types, constants and the cordic angle table of the trajectory shape classifier
// no dependencies
`default_nettype none

package tsc_pkg;

    localparam int MAX_STATES      = 128;
    localparam int ANGLE_FRAC_BITS = 12;
    localparam int COUNT_W         = 8;
    localparam int CORDIC_STEPS    = 20;
    localparam int STEP_W          = $clog2(CORDIC_STEPS);
    localparam int CORDIC_FRAC     = 16;
    localparam int V_W             = 52;
    localparam int Z_W             = 40;
    localparam int Z_SHIFT         = 30 - ANGLE_FRAC_BITS;
    localparam int D_W             = 33;
    localparam int SPEED_LIM_W     = 15;
    localparam int DIST_W          = 20;
    localparam int HEAD_W          = 16;
    localparam int HD_W            = HEAD_W + 1;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 21;

    localparam logic signed [Z_W-1:0] ANG_PI      = Z_W'(64'sd3373259426);
    localparam logic signed [Z_W-1:0] ANG_HALF_PI = Z_W'(64'sd1686629713);
    localparam logic signed [Z_W-1:0] ANG_TWO_PI  = Z_W'(64'sd6746518852);
    localparam logic signed [16:0]    INV_GAIN    = 17'sd39797;

    localparam logic [CFG_IDX_W-1:0] CFG_START_INDEX    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STILL_SPEED    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STILL_DISTANCE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LATERAL        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UTURN_FORWARD  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADING        = 3'd5;

    localparam logic [2:0] CLS_STATIONARY     = 3'd0;
    localparam logic [2:0] CLS_STRAIGHT       = 3'd1;
    localparam logic [2:0] CLS_STRAIGHT_LEFT  = 3'd2;
    localparam logic [2:0] CLS_STRAIGHT_RIGHT = 3'd3;
    localparam logic [2:0] CLS_LEFT_UTURN     = 3'd4;
    localparam logic [2:0] CLS_LEFT_TURN      = 3'd5;
    localparam logic [2:0] CLS_RIGHT_UTURN    = 3'd6;
    localparam logic [2:0] CLS_RIGHT_TURN     = 3'd7;

    typedef struct packed {
        logic                     state_valid;
        logic signed [31:0]       pos_x;
        logic signed [31:0]       pos_y;
        logic signed [HEAD_W-1:0] heading_angle;
        logic signed [15:0]       vel_x;
        logic signed [15:0]       vel_y;
        logic                     track_end;
    } t_in;

    typedef struct packed {
        logic       has_class;
        logic [2:0] motion_class;
    } t_out;

    typedef struct packed {
        logic [6:0]             start_index;
        logic [SPEED_LIM_W-1:0] still_speed_limit;
        logic [DIST_W-1:0]      still_distance_limit;
        logic [DIST_W-1:0]      lateral_limit;
        logic signed [20:0]     uturn_forward_limit;
        logic [14:0]            heading_limit;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        start_index:          7'd10,
        still_speed_limit:    15'd512,
        still_distance_limit: 20'd640,
        lateral_limit:        20'd640,
        uturn_forward_limit:  -21'sd640,
        heading_limit:        15'd2145
    };

    typedef struct packed {
        logic signed [31:0]       pos_x;
        logic signed [31:0]       pos_y;
        logic signed [HEAD_W-1:0] heading;
        logic signed [15:0]       vel_x;
        logic signed [15:0]       vel_y;
    } t_pose;

    typedef struct packed {
        logic  has;
        t_pose start_p;
        t_pose end_p;
    } t_job;

    function automatic logic [29:0] atan_entry(input logic [STEP_W-1:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:    v = 30'd843314856;
            5'd1:    v = 30'd497837829;
            5'd2:    v = 30'd263043836;
            5'd3:    v = 30'd133525158;
            5'd4:    v = 30'd67021686;
            5'd5:    v = 30'd33543515;
            5'd6:    v = 30'd16775850;
            5'd7:    v = 30'd8388437;
            5'd8:    v = 30'd4194282;
            5'd9:    v = 30'd2097149;
            5'd10:   v = 30'd1048575;
            5'd11:   v = 30'd524287;
            5'd12:   v = 30'd262143;
            5'd13:   v = 30'd131071;
            5'd14:   v = 30'd65535;
            5'd15:   v = 30'd32767;
            5'd16:   v = 30'd16383;
            5'd17:   v = 30'd8191;
            5'd18:   v = 30'd4095;
            5'd19:   v = 30'd2047;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/tsc_front.sv -----
// front end: counts states within a track, captures start and end states,
// hands a finished track to the track queue; depends on tsc_pkg
`default_nettype none

module tsc_front (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_accept,
    input  tsc_pkg::t_in      i_item,
    input  wire logic [6:0]   i_start_index,
    output logic              o_job_push,
    output tsc_pkg::t_job     o_job
);

    logic [tsc_pkg::COUNT_W-1:0] r_count, n_count;
    logic                        r_start_seen, n_start_seen;
    logic                        r_end_seen, n_end_seen;
    tsc_pkg::t_pose              r_start, n_start;
    tsc_pkg::t_pose              r_end, n_end;
    tsc_pkg::t_pose              w_pose;
    logic                        w_in_range;
    logic [tsc_pkg::COUNT_W-1:0] w_start_idx;

    assign w_pose = '{
        pos_x:   i_item.pos_x,
        pos_y:   i_item.pos_y,
        heading: i_item.heading_angle,
        vel_x:   i_item.vel_x,
        vel_y:   i_item.vel_y
    };
    assign w_in_range  = 32'(r_count) < 32'(tsc_pkg::MAX_STATES);
    assign w_start_idx = tsc_pkg::COUNT_W'(i_start_index);

    always_comb begin
        n_count      = r_count;
        n_start_seen = r_start_seen;
        n_end_seen   = r_end_seen;
        n_start      = r_start;
        n_end        = r_end;
        if (i_accept) begin
            if (w_in_range) begin
                if (r_count == w_start_idx) begin
                    n_start_seen = i_item.state_valid;
                    if (i_item.state_valid) begin
                        n_start = w_pose;
                    end
                end else if (r_count > w_start_idx && i_item.state_valid) begin
                    n_end_seen = 1'b1;
                    n_end      = w_pose;
                end
            end
            if (r_count != '1) begin
                n_count = r_count + 1'b1;
            end
        end
    end

    assign o_job_push = i_accept && i_item.track_end;
    assign o_job      = '{has: n_start_seen && n_end_seen, start_p: n_start, end_p: n_end};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_start_seen <= 1'b0;
            r_end_seen   <= 1'b0;
        end else if (o_job_push) begin
            r_count      <= '0;
            r_start_seen <= 1'b0;
            r_end_seen   <= 1'b0;
        end else begin
            r_count      <= n_count;
            r_start_seen <= n_start_seen;
            r_end_seen   <= n_end_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        r_start <= n_start;
        r_end   <= n_end;
    end

endmodule

`default_nettype wire

// ----- hdl/tsc_job_fifo.sv -----
// two-entry queue of finished tracks between front and back end
// depends on tsc_pkg
`default_nettype none

module tsc_job_fifo (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  tsc_pkg::t_job i_job,
    input  wire logic     i_pop,
    output tsc_pkg::t_job o_job,
    output logic          o_full,
    output logic          o_empty
);

    tsc_pkg::t_job r_mem [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_count;

    assign o_full  = r_count == 2'd2;
    assign o_empty = r_count == 2'd0;
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/tsc_back.sv -----
// back end: stationary test, iterative cordic rotation into the start frame,
// class decision; depends on tsc_pkg
`default_nettype none

module tsc_back (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  tsc_pkg::t_cfg i_cfg,
    input  wire logic     i_job_empty,
    input  tsc_pkg::t_job i_job,
    output logic          o_job_pop,
    input  wire logic     i_res_free,
    output logic          o_res_load,
    output tsc_pkg::t_out o_res
);

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_PREP   = 9'b000000010,
        ST_MAG    = 9'b000000100,
        ST_SQ     = 9'b000001000,
        ST_STILL  = 9'b000010000,
        ST_FOLD   = 9'b000100000,
        ST_CORD   = 9'b001000000,
        ST_DECIDE = 9'b010000000,
        ST_OUT    = 9'b100000000
    } t_back_state;

    localparam logic [tsc_pkg::STEP_W-1:0] STEP_LAST =
        tsc_pkg::STEP_W'(tsc_pkg::CORDIC_STEPS - 1);

    t_back_state r_state, n_state;
    logic [tsc_pkg::STEP_W-1:0] r_step;

    tsc_pkg::t_job                    r_job;
    logic signed [tsc_pkg::D_W-1:0]   r_dx, r_dy;
    logic signed [tsc_pkg::HD_W-1:0]  r_hd;
    logic [30:0]                      r_svx2, r_svy2, r_evx2, r_evy2;
    logic [31:0]                      r_ssq, r_esq;
    logic [2*tsc_pkg::SPEED_LIM_W-1:0] r_sl;
    logic [2*tsc_pkg::DIST_W-1:0]     r_dl2, r_ax2, r_ay2;
    logic [tsc_pkg::D_W-1:0]          r_ax, r_ay;
    logic                             r_near_x, r_near_y;
    logic signed [tsc_pkg::V_W-1:0]   r_x, r_y;
    logic signed [tsc_pkg::Z_W-1:0]   r_z;
    tsc_pkg::t_out                    r_res;

    logic signed [tsc_pkg::D_W-1:0]   w_dx, w_dy;
    logic signed [tsc_pkg::HD_W-1:0]  w_hd;
    logic signed [31:0]               w_svx2, w_svy2, w_evx2, w_evy2;
    logic [2*tsc_pkg::SPEED_LIM_W-1:0] w_sl;
    logic [2*tsc_pkg::DIST_W-1:0]     w_dl2, w_ax2, w_ay2;
    logic signed [tsc_pkg::Z_W-1:0]   w_z0;
    logic [tsc_pkg::D_W-1:0]          w_ax, w_ay;
    logic signed [tsc_pkg::V_W-1:0]   w_x0, w_y0;
    logic                             w_still;
    logic signed [tsc_pkg::V_W-1:0]   w_xs, w_ys;
    logic signed [tsc_pkg::Z_W-1:0]   w_atan;
    logic [tsc_pkg::V_W-1:0]          w_ly_mag, w_lat_lim;
    logic signed [tsc_pkg::V_W-1:0]   w_ut;
    logic signed [tsc_pkg::HD_W-1:0]  w_hl;
    logic [tsc_pkg::HD_W-1:0]         w_hd_mag;
    logic [2:0]                       w_cls;

    assign w_dx = tsc_pkg::D_W'(r_job.end_p.pos_x) - tsc_pkg::D_W'(r_job.start_p.pos_x);
    assign w_dy = tsc_pkg::D_W'(r_job.end_p.pos_y) - tsc_pkg::D_W'(r_job.start_p.pos_y);
    assign w_hd = tsc_pkg::HD_W'(r_job.end_p.heading) - tsc_pkg::HD_W'(r_job.start_p.heading);
    assign w_svx2 = r_job.start_p.vel_x * r_job.start_p.vel_x;
    assign w_svy2 = r_job.start_p.vel_y * r_job.start_p.vel_y;
    assign w_evx2 = r_job.end_p.vel_x * r_job.end_p.vel_x;
    assign w_evy2 = r_job.end_p.vel_y * r_job.end_p.vel_y;
    assign w_sl   = i_cfg.still_speed_limit * i_cfg.still_speed_limit;
    assign w_dl2  = i_cfg.still_distance_limit * i_cfg.still_distance_limit;
    assign w_z0   = -(tsc_pkg::Z_W'(r_job.start_p.heading) <<< tsc_pkg::Z_SHIFT);

    assign w_ax = r_dx[tsc_pkg::D_W-1] ? tsc_pkg::D_W'(-r_dx) : tsc_pkg::D_W'(r_dx);
    assign w_ay = r_dy[tsc_pkg::D_W-1] ? tsc_pkg::D_W'(-r_dy) : tsc_pkg::D_W'(r_dy);
    assign w_x0 = r_dx * tsc_pkg::INV_GAIN;
    assign w_y0 = r_dy * tsc_pkg::INV_GAIN;

    assign w_ax2 = r_ax[tsc_pkg::DIST_W-1:0] * r_ax[tsc_pkg::DIST_W-1:0];
    assign w_ay2 = r_ay[tsc_pkg::DIST_W-1:0] * r_ay[tsc_pkg::DIST_W-1:0];

    assign w_still = (r_ssq < 32'(r_sl)) && (r_esq < 32'(r_sl)) && r_near_x && r_near_y &&
        ((41'(r_ax2) + 41'(r_ay2)) < 41'(r_dl2));

    assign w_xs   = r_x >>> r_step;
    assign w_ys   = r_y >>> r_step;
    assign w_atan = $signed(tsc_pkg::Z_W'(tsc_pkg::atan_entry(r_step)));

    assign w_ly_mag  = r_y[tsc_pkg::V_W-1] ? tsc_pkg::V_W'(-r_y) : tsc_pkg::V_W'(r_y);
    assign w_lat_lim = tsc_pkg::V_W'(i_cfg.lateral_limit) << tsc_pkg::CORDIC_FRAC;
    assign w_ut      = tsc_pkg::V_W'(i_cfg.uturn_forward_limit) <<< tsc_pkg::CORDIC_FRAC;
    assign w_hl      = $signed(tsc_pkg::HD_W'(i_cfg.heading_limit));
    assign w_hd_mag  = r_hd[tsc_pkg::HD_W-1] ? tsc_pkg::HD_W'(-r_hd) : tsc_pkg::HD_W'(r_hd);

    always_comb begin
        if (w_hd_mag < tsc_pkg::HD_W'(w_hl)) begin
            if (w_ly_mag < w_lat_lim) begin
                w_cls = tsc_pkg::CLS_STRAIGHT;
            end else if (r_y[tsc_pkg::V_W-1]) begin
                w_cls = tsc_pkg::CLS_STRAIGHT_RIGHT;
            end else begin
                w_cls = tsc_pkg::CLS_STRAIGHT_LEFT;
            end
        end else if (r_hd < -w_hl && r_y[tsc_pkg::V_W-1]) begin
            w_cls = (r_x < w_ut) ? tsc_pkg::CLS_RIGHT_UTURN : tsc_pkg::CLS_RIGHT_TURN;
        end else begin
            w_cls = (r_x < w_ut) ? tsc_pkg::CLS_LEFT_UTURN : tsc_pkg::CLS_LEFT_TURN;
        end
    end

    assign o_job_pop  = (r_state == ST_IDLE) && !i_job_empty;
    assign o_res_load = (r_state == ST_OUT) && i_res_free;
    assign o_res      = r_res;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (!i_job_empty) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP:  n_state = r_job.has ? ST_MAG : ST_OUT;
            ST_MAG:   n_state = ST_SQ;
            ST_SQ:    n_state = ST_STILL;
            ST_STILL: n_state = w_still ? ST_OUT : ST_FOLD;
            ST_FOLD: begin
                if (r_z <= tsc_pkg::ANG_PI && r_z >= -tsc_pkg::ANG_PI) begin
                    n_state = ST_CORD;
                end
            end
            ST_CORD: begin
                if (r_step == STEP_LAST) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: n_state = ST_OUT;
            ST_OUT: begin
                if (i_res_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_FOLD) begin
                r_step <= '0;
            end else if (r_state == ST_CORD) begin
                r_step <= r_step + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_job <= i_job;
            end
            ST_PREP: begin
                r_dx   <= w_dx;
                r_dy   <= w_dy;
                r_hd   <= w_hd;
                r_svx2 <= w_svx2[30:0];
                r_svy2 <= w_svy2[30:0];
                r_evx2 <= w_evx2[30:0];
                r_evy2 <= w_evy2[30:0];
                r_sl   <= w_sl;
                r_dl2  <= w_dl2;
                r_z    <= w_z0;
                r_res  <= '{has_class: 1'b0, motion_class: tsc_pkg::CLS_STATIONARY};
            end
            ST_MAG: begin
                r_ax  <= w_ax;
                r_ay  <= w_ay;
                r_ssq <= 32'(r_svx2) + 32'(r_svy2);
                r_esq <= 32'(r_evx2) + 32'(r_evy2);
                r_x   <= w_x0;
                r_y   <= w_y0;
            end
            ST_SQ: begin
                r_near_x <= r_ax < tsc_pkg::D_W'(i_cfg.still_distance_limit);
                r_near_y <= r_ay < tsc_pkg::D_W'(i_cfg.still_distance_limit);
                r_ax2    <= w_ax2;
                r_ay2    <= w_ay2;
            end
            ST_STILL: begin
                r_res <= '{has_class: 1'b1, motion_class: tsc_pkg::CLS_STATIONARY};
            end
            ST_FOLD: begin
                if (r_z > tsc_pkg::ANG_PI) begin
                    r_z <= r_z - tsc_pkg::ANG_TWO_PI;
                end else if (r_z < -tsc_pkg::ANG_PI) begin
                    r_z <= r_z + tsc_pkg::ANG_TWO_PI;
                end else if (r_z > tsc_pkg::ANG_HALF_PI) begin
                    r_x <= -r_y;
                    r_y <= r_x;
                    r_z <= r_z - tsc_pkg::ANG_HALF_PI;
                end else if (r_z < -tsc_pkg::ANG_HALF_PI) begin
                    r_x <= r_y;
                    r_y <= -r_x;
                    r_z <= r_z + tsc_pkg::ANG_HALF_PI;
                end
            end
            ST_CORD: begin
                if (!r_z[tsc_pkg::Z_W-1]) begin
                    r_x <= r_x - w_ys;
                    r_y <= r_y + w_xs;
                    r_z <= r_z - w_atan;
                end else begin
                    r_x <= r_x + w_ys;
                    r_y <= r_y - w_xs;
                    r_z <= r_z + w_atan;
                end
            end
            ST_DECIDE: begin
                r_res <= '{has_class: 1'b1, motion_class: w_cls};
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/trajectory_shape_classifier_top.sv -----
// trajectory shape classifier: config registers, front end, track queue, back end, result register
// throughput: one state request per cycle while the two-entry track queue has room
// the back end's iterative cordic sets the track rate and takes a new track only
// after the last result is loaded; stationary and no-class tracks skip the cordic
// synchronous active-low reset clears track state, the track queue and config to defaults
`default_nettype none
`include "trajectory_shape_classifier_top_macros.svh"

module trajectory_shape_classifier_top (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             push,
    output logic                                  full,
    input  tsc_pkg::t_in                          i_item,
    output logic                                  empty,
    input  wire logic                             pop,
    output tsc_pkg::t_out                         o_result,
    input  wire logic                             i_cfg_wr_en,
    input  wire logic [tsc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [tsc_pkg::CFG_DATA_W-1:0]   i_cfg_wr_data
);

    tsc_pkg::t_cfg r_cfg;
    tsc_pkg::t_out r_out;
    logic          r_out_valid;

    logic          w_accept;
    logic          w_job_push;
    tsc_pkg::t_job w_job_in;
    tsc_pkg::t_job w_job_out;
    logic          w_job_pop;
    logic          w_job_full;
    logic          w_job_empty;
    logic          w_res_free;
    logic          w_res_load;
    tsc_pkg::t_out w_res;

    assign w_accept   = push && !w_job_full;
    assign full       = w_job_full;
    assign empty      = !r_out_valid;
    assign o_result   = r_out;
    assign w_res_free = !r_out_valid || pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= tsc_pkg::CFG_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                tsc_pkg::CFG_START_INDEX:    r_cfg.start_index <= i_cfg_wr_data[6:0];
                tsc_pkg::CFG_STILL_SPEED:
                    r_cfg.still_speed_limit <= i_cfg_wr_data[tsc_pkg::SPEED_LIM_W-1:0];
                tsc_pkg::CFG_STILL_DISTANCE:
                    r_cfg.still_distance_limit <= i_cfg_wr_data[tsc_pkg::DIST_W-1:0];
                tsc_pkg::CFG_LATERAL:
                    r_cfg.lateral_limit <= i_cfg_wr_data[tsc_pkg::DIST_W-1:0];
                tsc_pkg::CFG_UTURN_FORWARD:
                    r_cfg.uturn_forward_limit <= $signed(i_cfg_wr_data[20:0]);
                tsc_pkg::CFG_HEADING:        r_cfg.heading_limit <= i_cfg_wr_data[14:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_load) begin
            r_out_valid <= 1'b1;
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_load) begin
            r_out <= w_res;
        end
    end

    tsc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_item        (i_item),
        .i_start_index (r_cfg.start_index),
        .o_job_push    (w_job_push),
        .o_job         (w_job_in)
    );

    tsc_job_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_job_push),
        .i_job   (w_job_in),
        .i_pop   (w_job_pop),
        .o_job   (w_job_out),
        .o_full  (w_job_full),
        .o_empty (w_job_empty)
    );

    tsc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_empty (w_job_empty),
        .i_job       (w_job_out),
        .o_job_pop   (w_job_pop),
        .i_res_free  (w_res_free),
        .o_res_load  (w_res_load),
        .o_res       (w_res)
    );

    `TSC_ASSERT_IMPL(a_job_push_room, i_clk, i_rst_n, w_job_push, !w_job_full)
    `TSC_ASSERT_IMPL(a_job_pop_avail, i_clk, i_rst_n, w_job_pop, !w_job_empty)
    `TSC_ASSERT_NEXT(a_res_shown, i_clk, i_rst_n, w_res_load, !empty)

endmodule

`default_nettype wire
